### rtl/hpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared types and constants for the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

  localparam int unsigned POOL_SIZE    = 256;
  localparam int unsigned HandleW      = 8;
  localparam int unsigned HandleSpace  = 1 << HandleW;
  localparam int unsigned FreshLimit   = (POOL_SIZE > HandleSpace) ? HandleSpace : POOL_SIZE;
  localparam int unsigned CountW       = HandleW + 1;

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [CountW-1:0]  count_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_TRY     = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE      = 2'd1,
    STAT_INVALID   = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

endpackage

### rtl/hpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/handle_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator
// FIFO free-list handle allocator: allocate, try-allocate and release.
// ----------------------------------------------------------------------------
// Flow: a start beat taken in S_IDLE moves the FSM to S_EXEC; done_o is
//   registered out of S_EXEC. A new request is taken only back in S_IDLE;
//   each is a read of the free-list and in-use RAMs followed by a write-back.
// Reset: after rst_ni rises the in-use RAM is swept clear with busy_o
//   high. The result has no back-pressure.
module handle_pool_allocator
  import hpa_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [1:0]    func_i,
  input  logic [7:0]    handle_i,
  output logic          done_o,
  output logic [7:0]    granted_handle_o,
  output logic [1:0]    status_o
);

  state_e  state_q, state_d;
  handle_t clr_q, clr_d;
  count_t  fresh_q, fresh_d;
  handle_t head_q, head_d;
  handle_t tail_q, tail_d;
  count_t  count_q, count_d;
  logic    done_q, done_d;

  logic [1:0] func_q;
  handle_t    handle_q;
  handle_t    grant_q, grant_d;
  logic [1:0] status_q, status_d;

  logic    queue_we;
  handle_t queue_rdata;
  logic    map_we;
  handle_t map_waddr;
  logic    map_wdata;
  logic    map_rdata;

  hpa_ram #(.WIDTH(HandleW), .DEPTH(HandleSpace)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (tail_q),
    .wdata_i (handle_q),
    .raddr_i (head_q),
    .rdata_o (queue_rdata)
  );

  hpa_ram #(.WIDTH(1), .DEPTH(HandleSpace)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (handle_i),
    .rdata_o (map_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    fresh_d   = fresh_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    done_d    = 1'b0;
    grant_d   = grant_q;
    status_d  = status_q;
    queue_we  = 1'b0;
    map_we    = 1'b0;
    map_waddr = clr_q;
    map_wdata = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        map_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (clr_q == handle_t'(HandleSpace - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        grant_d  = '0;
        status_d = STAT_OK;
        if (func_q == FUNC_ALLOC || func_q == FUNC_TRY) begin
          if (count_q != '0) begin
            grant_d   = queue_rdata;
            head_d    = head_q + 1'b1;
            count_d   = count_q - 1'b1;
            map_we    = 1'b1;
            map_waddr = queue_rdata;
            map_wdata = 1'b1;
          end else if (func_q == FUNC_TRY) begin
            status_d = STAT_NONE;
          end else if (fresh_q < count_t'(FreshLimit)) begin
            grant_d   = fresh_q[HandleW-1:0];
            fresh_d   = fresh_q + 1'b1;
            map_we    = 1'b1;
            map_waddr = fresh_q[HandleW-1:0];
            map_wdata = 1'b1;
          end else begin
            status_d = STAT_EXHAUSTED;
          end
        end else if (func_q == FUNC_RELEASE) begin
          if (map_rdata) begin
            map_we    = 1'b1;
            map_waddr = handle_q;
            map_wdata = 1'b0;
            queue_we  = 1'b1;
            tail_d    = tail_q + 1'b1;
            count_d   = count_q + 1'b1;
          end else begin
            status_d = STAT_INVALID;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      fresh_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      fresh_q <= fresh_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      func_q   <= func_i;
      handle_q <= handle_i;
    end
    grant_q  <= grant_d;
    status_q <= status_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign granted_handle_o = grant_q;
  assign status_o         = status_q;

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_EXEC))
    else $error("result beat without a write-back cycle");

  a_start_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_EXEC))
    else $error("accepted beat not processed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= count_t'(HandleSpace))
    else $error("free list count overflow");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STAT_OK) |-> (grant_q == '0))
    else $error("handle granted on a failed request");

endmodule
